// File: sv/ilir_pkg.sv
// Shared types and constants of the indexed list block: operation and status
// codes, cell commands, field widths and parameter defaults.
// No dependencies.
`default_nettype none

package ilir_pkg;

  // Defaults for the top level parameters
  localparam int ILIR_CAPACITY    = 16;
  localparam int ILIR_ENTRY_WIDTH = 64;

  // Fixed field widths of the word ports
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_REM_LAST = 3'd2,
    OP_REM_AT   = 3'd3,
    OP_ITERATE  = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CC_HOLD   = 3'd0,
    CC_LOAD   = 3'd1,  // write word at pos
    CC_INSERT = 3'd2,  // write word at pos, cells above take left neighbor
    CC_REMOVE = 3'd3,  // cells at and above pos take right neighbor
    CC_ROTATE = 3'd4   // cells below pos take right neighbor, pos takes head
  } cell_cmd_t;

endpackage : ilir_pkg

`default_nettype wire

// File: sv/ilir_cell.sv
// One storage cell of the list chain: holds a single entry and updates it
// from its neighbors, the head cell or the new word. Uses ilir_pkg.
`default_nettype none

module ilir_cell #(
  parameter int ENTRY_WIDTH = 64,
  parameter int POS_W       = 5,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire ilir_pkg::cell_cmd_t    cmd,
  input  wire logic [POS_W-1:0]       pos,
  input  wire logic [ENTRY_WIDTH-1:0] word,
  input  wire logic [ENTRY_WIDTH-1:0] left,
  input  wire logic [ENTRY_WIDTH-1:0] right,
  input  wire logic [ENTRY_WIDTH-1:0] head,
  output logic      [ENTRY_WIDTH-1:0] data
);
  import ilir_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [ENTRY_WIDTH-1:0] data_next;

  // Next entry from the broadcast command and this cell's position
  always_comb begin
    data_next = data;
    unique case (cmd)
      CC_HOLD: ;
      CC_LOAD: begin
        if (MY_POS == pos) data_next = word;
      end
      CC_INSERT: begin
        if (MY_POS == pos)     data_next = word;
        else if (MY_POS > pos) data_next = left;
      end
      CC_REMOVE: begin
        if (MY_POS >= pos) data_next = right;
      end
      CC_ROTATE: begin
        if (MY_POS < pos)       data_next = right;
        else if (MY_POS == pos) data_next = head;
      end
      default: ;
    endcase
  end

  // Payload register, no reset (contents undefined until written)
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule : ilir_cell

`default_nettype wire

// File: sv/ilir_chain.sv
// Row of CAPACITY list cells wired to their neighbors; cell 0 is the head
// and is read out during iteration. Uses ilir_pkg and ilir_cell.
`default_nettype none

module ilir_chain #(
  parameter int CAPACITY    = ilir_pkg::ILIR_CAPACITY,
  parameter int ENTRY_WIDTH = ilir_pkg::ILIR_ENTRY_WIDTH,
  parameter int POS_W       = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk,
  input  wire ilir_pkg::cell_cmd_t    cmd,
  input  wire logic [POS_W-1:0]       pos,
  input  wire logic [ENTRY_WIDTH-1:0] word,
  output logic      [ENTRY_WIDTH-1:0] head
);
  import ilir_pkg::*;

  logic [ENTRY_WIDTH-1:0] data [CAPACITY];

  assign head = data[0];

  // Each cell sees its neighbors; the ends see their own entry
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_d;
    logic [ENTRY_WIDTH-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = data[g];
    end else begin : g_mid_l
      assign left_d = data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = data[g];
    end else begin : g_mid_r
      assign right_d = data[g+1];
    end

    ilir_cell #(
      .ENTRY_WIDTH(ENTRY_WIDTH),
      .POS_W      (POS_W),
      .IDX        (g)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .pos  (pos),
      .word (word),
      .left (left_d),
      .right(right_d),
      .head (data[0]),
      .data (data[g])
    );
  end

endmodule : ilir_chain

`default_nettype wire

// File: sv/indexed_list_insert_remove_top.sv
// Top level of the indexed list: op decode, fill count, iterate sequencer
// and output register around the cell chain. Uses ilir_pkg and ilir_chain.
//
//   channel | signals                                   | flow
//   --------+-------------------------------------------+--------------------
//   in      | in_valid, in_stall, op, index, entry_in   | ops into the list
//   out     | out_valid, out_stall, status, entry_out,  | one word per result
//           | entry_valid, last, count                  |
//
// Append, insert and remove update the whole chain at once and failed ops change
// nothing, so a new word is taken every cycle while out is not stalled.
// Iterate: the chain rotates one place per emitted entry
// and returns to its original order after the last one; input stalls meanwhile.
// Reset clears the fill count, the sequencer and out_valid; cells and the
// result payload have no reset.
// A stall on out holds the result and blocks new input words.
`default_nettype none

module indexed_list_insert_remove_top #(
  parameter int CAPACITY    = ilir_pkg::ILIR_CAPACITY,
  parameter int ENTRY_WIDTH = ilir_pkg::ILIR_ENTRY_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ilir_pkg::OP_W-1:0]       op,
  input  wire logic [ilir_pkg::INDEX_W-1:0]    index,
  input  wire logic [ilir_pkg::WORD_W-1:0]     entry_in,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [ilir_pkg::STATUS_W-1:0]   status,
  output logic      [ilir_pkg::WORD_W-1:0]     entry_out,
  output logic                                 entry_valid,
  output logic                                 last,
  output logic      [ilir_pkg::COUNT_W-1:0]    count
);
  import ilir_pkg::*;

  localparam int FW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (FW > INDEX_W) ? FW : INDEX_W;
  localparam logic [FW-1:0] FULL_FILL = FW'(CAPACITY);
  localparam logic [FW-1:0] ONE       = FW'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ITER = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [FW-1:0]   fill, fill_next;
  logic [FW-1:0]   iter_cnt, iter_cnt_next;

  cell_cmd_t              cmd;
  logic [FW-1:0]          pos;
  logic [ENTRY_WIDTH-1:0] head;

  logic                   load_ok, accept, iter_step, load_out;
  status_t                res_status;
  logic [WORD_W-1:0]      res_entry;
  logic                   res_valid, res_last;

  logic [CMP_W-1:0]       idx_w, fill_w;
  logic                   is_full, is_empty, idx_bad;

  // Handshake
  assign load_ok   = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !load_ok;
  assign accept    = in_valid && !in_stall;
  assign iter_step = (state == S_ITER) && load_ok;

  assign idx_w    = CMP_W'(index);
  assign fill_w   = CMP_W'(fill);
  assign is_full  = (fill == FULL_FILL);
  assign is_empty = (fill == '0);
  assign idx_bad  = (idx_w >= fill_w);

  // Op decode, chain command and iterate sequencing
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    iter_cnt_next = iter_cnt;
    cmd           = CC_HOLD;
    pos           = fill;
    load_out      = 1'b0;
    res_status    = ST_OK;
    res_entry     = '0;
    res_valid     = 1'b0;
    res_last      = 1'b1;

    if (accept) begin
      load_out = 1'b1;
      unique case (op)
        OP_APPEND: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            cmd       = CC_LOAD;
            pos       = fill;
            fill_next = fill + ONE;
          end
        end
        OP_INSERT: begin
          if (idx_bad) begin
            res_status = ST_RANGE;
          end else if (is_full) begin
            res_status = ST_FULL;
          end else begin
            cmd       = CC_INSERT;
            pos       = FW'(idx_w);
            fill_next = fill + ONE;
          end
        end
        OP_REM_LAST: begin
          if (is_empty) res_status = ST_EMPTY;
          else          fill_next  = fill - ONE;
        end
        OP_REM_AT: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else if (idx_bad) begin
            res_status = ST_RANGE;
          end else begin
            cmd       = CC_REMOVE;
            pos       = FW'(idx_w);
            fill_next = fill - ONE;
          end
        end
        OP_ITERATE: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            load_out      = 1'b0;
            state_next    = S_ITER;
            iter_cnt_next = '0;
          end
        end
        default: ;  // unknown op: no change, status ok
      endcase
    end else if (iter_step) begin
      // emit head, rotate the filled part of the chain by one
      load_out      = 1'b1;
      res_entry     = WORD_W'(head);
      res_valid     = 1'b1;
      res_last      = (iter_cnt == fill - ONE);
      cmd           = CC_ROTATE;
      pos           = fill - ONE;
      iter_cnt_next = iter_cnt + ONE;
      if (res_last) state_next = S_IDLE;
    end
  end

  ilir_chain #(
    .CAPACITY   (CAPACITY),
    .ENTRY_WIDTH(ENTRY_WIDTH),
    .POS_W      (FW)
  ) u_chain (
    .clk (clk),
    .cmd (cmd),
    .pos (pos),
    .word(entry_in[ENTRY_WIDTH-1:0]),
    .head(head)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      iter_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      iter_cnt <= iter_cnt_next;
      if (load_out)      out_valid <= 1'b1;
      else if (load_ok)  out_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      entry_out   <= res_entry;
      entry_valid <= res_valid;
      last        <= res_last;
      count       <= COUNT_W'(fill_next);
    end
  end

endmodule : indexed_list_insert_remove_top

`default_nettype wire

// File: sv/ilir_checker.sv
// Port-level checks of the indexed list top level, attached by bind.
// Uses ilir_pkg.
`default_nettype none

module ilir_checker #(
  parameter int CAPACITY    = ilir_pkg::ILIR_CAPACITY
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ilir_pkg::STATUS_W-1:0] status,
  input wire logic [ilir_pkg::WORD_W-1:0]   entry_out,
  input wire logic                          entry_valid,
  input wire logic                          last,
  input wire logic [ilir_pkg::COUNT_W-1:0]  count
);
  import ilir_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(CAPACITY);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_out)
      && $stable(last) && $stable(count))
    else $error("stalled result word changed");

  // Stored records only come with status ok
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> status == ST_OK)
    else $error("record emitted with bad status");

  // Results without a record carry zero
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> entry_out == '0 && last)
    else $error("non-record result malformed");

  // Empty status only on an empty list
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0)
    else $error("empty status with nonzero count");

  // Full status only at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == FULL_CNT)
    else $error("full status below capacity");

endmodule : ilir_checker

bind indexed_list_insert_remove_top ilir_checker #(
  .CAPACITY   (CAPACITY)
) u_ilir_checker (.*);

`default_nettype wire

// File: verif/indexed_list_insert_remove_top_test.sv
// Self-checking testbench of indexed_list_insert_remove_top: a directed table and random
// list operations under varied sender and receiver pacing, checked against a behavioral list.
// Depends on ilir_pkg and the indexed_list_insert_remove_top RTL.

module indexed_list_insert_remove_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  localparam int CAP          = ILIR_CAPACITY;
  localparam int DRAIN_CYCLES = 2 * CAP + 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;

  // op codes that the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  entry;
    bit                 typed;       // result written in the table below
    status_t            exp_status;
    logic [COUNT_W-1:0] exp_count;
  } list_cmd_t;

  typedef struct {
    list_cmd_t cmd;
    int        reps;                 // more than one: random entries
  } dir_row_t;

  typedef struct {
    status_t            status;
    logic [WORD_W-1:0]  entry;
    logic               entry_valid;
    logic               last;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op        = '0;
  logic [INDEX_W-1:0] index     = '0;
  logic [WORD_W-1:0]  entry_in  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]  entry_out;
  logic               entry_valid;
  logic               last;
  logic [COUNT_W-1:0] count;

  indexed_list_insert_remove_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .index      (index),
    .entry_in   (entry_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .entry_out  (entry_out),
    .entry_valid(entry_valid),
    .last       (last),
    .count      (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  list_cmd_t    queued_list_ops[$];
  list_result_t pending_list_results[$];
  list_result_t op_results[$];
  list_cmd_t    offered;

  // Behavioral copy of the list
  logic [WORD_W-1:0] list_cells [CAP];
  int                held = 0;

  // Pacing knobs: percentages set by the main thread on falling edges, hold_off on rising edges
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  logic hold_off     = 1'b0;

  int  mismatches = 0;
  int  cycles     = 0;

  // Fill level as seen by the generator, updated when an op is queued, ahead of acceptance
  int  plan_fill = 0;
  bit  grow_mode = 1'b1;

  // Expected results of one list operation, left in op_results
  function automatic void run_list_op(list_cmd_t c);
    status_t      st;
    list_result_t r;
    int           k;
    st = ST_OK;
    op_results.delete();
    case (c.op)
      OP_APPEND:
        if (held == CAP) st = ST_FULL;
        else begin
          list_cells[held] = c.entry;
          held++;
        end
      OP_INSERT:
        if (c.idx >= held) st = ST_RANGE;
        else if (held == CAP) st = ST_FULL;
        else begin
          for (k = held; k > c.idx; k--) list_cells[k] = list_cells[k-1];
          list_cells[c.idx] = c.entry;
          held++;
        end
      OP_REM_LAST:
        if (held == 0) st = ST_EMPTY;
        else held--;
      OP_REM_AT:
        if (held == 0) st = ST_EMPTY;
        else if (c.idx >= held) st = ST_RANGE;
        else begin
          for (k = c.idx; k + 1 < held; k++) list_cells[k] = list_cells[k+1];
          held--;
        end
      OP_ITERATE:
        if (held == 0) st = ST_EMPTY;
        else begin
          for (k = 0; k < held; k++) begin
            r = '{ST_OK, list_cells[k], 1'b1, (k + 1 == held), COUNT_W'(held)};
            op_results.push_back(r);
          end
          return;
        end
      default: ;
    endcase
    r = '{st, '0, 1'b0, 1'b1, COUNT_W'(held)};
    op_results.push_back(r);
  endfunction

  // Fill level after an op, used only to shape the stimulus
  function automatic int next_fill(list_cmd_t c, int f);
    case (c.op)
      OP_APPEND:   return (f < CAP) ? f + 1 : f;
      OP_INSERT:   return (c.idx < f && f < CAP) ? f + 1 : f;
      OP_REM_LAST: return (f > 0) ? f - 1 : f;
      OP_REM_AT:   return (f > 0 && c.idx < f) ? f - 1 : f;
      default:     return f;
    endcase
  endfunction

  function automatic void queue_cmd(list_cmd_t c);
    queued_list_ops.push_back(c);
    plan_fill = next_fill(c, plan_fill);
  endfunction

  // Mostly well-formed ops with valid indices, steered to sweep empty to full
  function automatic list_cmd_t pick_list_op();
    list_cmd_t c;
    int        r;
    c = '{OP_ITERATE, '0, {$urandom, $urandom}, 1'b0, ST_OK, '0};
    if (plan_fill == CAP && $urandom_range(1) == 1) grow_mode = 1'b0;
    if (plan_fill == 0) grow_mode = 1'b1;
    else if ($urandom_range(99) < 4) grow_mode = !grow_mode;
    if ($urandom_range(99) < 15) begin
      // noise: any code, any index
      c.op  = OP_W'($urandom_range(7));
      c.idx = INDEX_W'($urandom_range(15));
      return c;
    end
    c.idx = (plan_fill > 0) ? INDEX_W'($urandom_range(plan_fill - 1))
                            : INDEX_W'($urandom_range(15));
    r = $urandom_range(99);
    if (grow_mode) begin
      if (r < 40) c.op = OP_APPEND;
      else if (r < 65) c.op = OP_INSERT;
      else if (r < 72) c.op = OP_REM_LAST;
      else if (r < 82) c.op = OP_REM_AT;
    end else begin
      if (r < 10) c.op = OP_APPEND;
      else if (r < 20) c.op = OP_INSERT;
      else if (r < 45) c.op = OP_REM_LAST;
      else if (r < 78) c.op = OP_REM_AT;
    end
    return c;
  endfunction

  function automatic void cmp_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: offer queued words, hold them while stalled, record on acceptance
  always @(posedge clk) begin : sender
    int i;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        run_list_op(offered);
        if (offered.typed)
          pending_list_results.push_back('{offered.exp_status, '0, 1'b0, 1'b1,
                                           offered.exp_count});
        else
          for (i = 0; i < op_results.size(); i++)
            pending_list_results.push_back(op_results[i]);
      end
      if (!(in_valid && in_stall)) begin
        if (queued_list_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_list_ops.pop_front();
          in_valid <= 1'b1;
          op       <= offered.op;
          index    <= offered.idx;
          entry_in <= offered.entry;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted word with the oldest expectation
  always @(posedge clk) begin : receiver
    list_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_list_results.size() == 0) begin
        $error("unexpected result word: status %0d count %0d", status, count);
        mismatches++;
      end else begin
        e = pending_list_results.pop_front();
        cmp_field("status", e.status, status);
        cmp_field("entry_out", e.entry, entry_out);
        cmp_field("entry_valid", e.entry_valid, entry_valid);
        cmp_field("last", e.last, last);
        cmp_field("count", e.count, count);
      end
    end
    out_stall <= hold_off || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("indexed_list_insert_remove_top_test NOT OK");
      $finish;
    end
  end

  // Directed table: typed rows carry their result, the rest go through the model
  dir_row_t directed_rows[] = '{
    '{'{OP_ITERATE,  4'd0,  64'h0, 1'b1, ST_EMPTY, 5'd0}, 1},
    '{'{OP_REM_LAST, 4'd0,  64'h0, 1'b1, ST_EMPTY, 5'd0}, 1},
    '{'{OP_REM_AT,   4'd15, 64'h0, 1'b1, ST_EMPTY, 5'd0}, 1},
    '{'{OP_INSERT,   4'd0,  '1,    1'b1, ST_RANGE, 5'd0}, 1},
    '{'{OP_SPARE_LO, 4'd15, '1,    1'b1, ST_OK,    5'd0}, 1},
    '{'{OP_SPARE_HI, 4'd0,  64'h0, 1'b1, ST_OK,    5'd0}, 1},
    '{'{OP_APPEND,   4'd0,  64'h0, 1'b1, ST_OK,    5'd1}, 1},
    '{'{OP_INSERT,   4'd1,  '1,    1'b1, ST_RANGE, 5'd1}, 1},
    '{'{OP_INSERT,   4'd0,  '1,    1'b1, ST_OK,    5'd2}, 1},
    '{'{OP_REM_AT,   4'd15, 64'h0, 1'b1, ST_RANGE, 5'd2}, 1},
    '{'{OP_ITERATE,  4'd0,  64'h0, 1'b0, ST_OK,    5'd0}, 1},
    '{'{OP_REM_AT,   4'd0,  64'h0, 1'b1, ST_OK,    5'd1}, 1},
    '{'{OP_REM_LAST, 4'd0,  64'h0, 1'b1, ST_OK,    5'd0}, 1},
    '{'{OP_APPEND,   4'd0,  64'h0, 1'b0, ST_OK,    5'd0}, CAP},
    '{'{OP_APPEND,   4'd7,  '1,    1'b1, ST_FULL,  5'd16}, 1},
    '{'{OP_INSERT,   4'd15, '1,    1'b1, ST_FULL,  5'd16}, 1},
    '{'{OP_ITERATE,  4'd0,  64'h0, 1'b0, ST_OK,    5'd0}, 1},
    '{'{OP_REM_AT,   4'd15, 64'h0, 1'b1, ST_OK,    5'd15}, 1},
    '{'{OP_INSERT,   4'd0,  64'h5555_5555_5555_5555, 1'b1, ST_OK, 5'd16}, 1},
    '{'{OP_ITERATE,  4'd0,  64'h0, 1'b0, ST_OK,    5'd0}, 1},
    '{'{OP_REM_AT,   4'd0,  64'h0, 1'b1, ST_OK,    5'd15}, 1},
    '{'{OP_ITERATE,  4'd0,  64'h0, 1'b0, ST_OK,    5'd0}, 1}
  };

  // Main sequence
  initial begin : main_seq
    list_cmd_t c;
    int        ph;
    int        n;
    int        r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, no idling
    foreach (directed_rows[n]) begin
      for (r = 0; r < directed_rows[n].reps; r++) begin
        c = directed_rows[n].cmd;
        if (directed_rows[n].reps > 1) c.entry = {$urandom, $urandom};
        queue_cmd(c);
      end
    end
    while (queued_list_ops.size() != 0 || in_valid) @(negedge clk);

    // random part under four pacing mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (n = 0; n < 18; n++) queue_cmd(pick_list_op());
      while (queued_list_ops.size() != 0 || in_valid) @(negedge clk);
    end

    // long receiver hold-off while words keep coming, so the input backs up
    send_idle_pct = 0;
    stall_pct     = 0;
    fork
      begin
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (n = 0; n < 20; n++) queue_cmd(pick_list_op());

    while (queued_list_ops.size() != 0 || in_valid || hold_off ||
           pending_list_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_list_results.size() == 0)
      $display("indexed_list_insert_remove_top_test OK");
    else
      $display("indexed_list_insert_remove_top_test NOT OK");
    $finish;
  end

endmodule
